/* design/aots_pkg.sv */
// Package for the alphabet order topological sort block.
// Holds sizes, transfer payload types, operation codes and controller interface types.
// No dependencies.
`timescale 1ns / 1ps
package aots_pkg;
    localparam int MAX_WORD_LEN = 64;
    localparam int MAX_EDGES    = 256;
    localparam int LETTERS      = 26;
    localparam int POS_W        = $clog2(MAX_WORD_LEN);
    localparam int EDGE_W       = $clog2(MAX_EDGES);
    localparam int LET_W        = 5;

    localparam logic [1:0] OP_LETTER = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] letter;
    } t_in;

    typedef struct packed {
        logic [4:0] order_letter;
        logic       present;
        logic       last;
    } t_out;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CMP   = 11'b00000000010,
        S_COPYR = 11'b00000000100,
        S_COPYW = 11'b00000001000,
        S_MARKR = 11'b00000010000,
        S_MARKW = 11'b00000100000,
        S_SCAN  = 11'b00001000000,
        S_DEQ   = 11'b00010000000,
        S_EDGE  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_CLEAR = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic take;      // store letter, read previous word at position
        logic cmp;       // compare step
        logic end_word;  // finish word bookkeeping
        logic copy_rd;
        logic copy_wr;
        logic mark_rd;
        logic mark_wr;
        logic scan;
        logic deq;
        logic edge_rd;
        logic edge_step;
        logic emit;
        logic clear;
        logic cnt_rst;
        logic head_rst;  // rewind queue head before emitting
    } t_cmd;

    typedef struct packed {
        logic cur_nonzero;
        logic copy_done;
        logic mark_done;
        logic scan_done;
        logic queue_empty;
        logic edge_done;
        logic emit_last;
    } t_sts;
endpackage

/* design/aots_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aots_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/aots_datapath.sv */
// Datapath: word stores, edge list, indegrees, seen set, Kahn queue.
// Depends on aots_pkg and aots_ram.
`timescale 1ns / 1ps
module aots_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  aots_pkg::t_in    i_item,
    input  aots_pkg::t_cmd   i_cmd,
    output aots_pkg::t_sts   o_sts,
    output aots_pkg::t_out   o_res
);
    import aots_pkg::*;

    logic [POS_W:0]    r_prev_len, n_prev_len;
    logic [POS_W:0]    r_cur_pos, n_cur_pos;
    logic              r_diff, n_diff;
    logic [LETTERS-1:0] r_seen, n_seen;
    logic [EDGE_W:0]   r_indeg [LETTERS];
    logic [EDGE_W:0]   r_edge_cnt;
    logic [POS_W:0]    r_idx;
    logic [EDGE_W:0]   r_eidx;
    logic [4:0]        r_fill, r_head;
    logic [4:0]        r_deq;
    logic [4:0]        r_letter;
    logic              r_cmp_ok;
    logic [LET_W-1:0]  r_q [LETTERS];

    logic [LET_W-1:0]  w_prev_rd, w_cur_rd;
    logic [2*LET_W-1:0] w_edge_rd;
    logic              w_edge_we;
    logic [POS_W-1:0]  w_prev_raddr;
    logic [LET_W-1:0]  w_a;
    logic [4:0]        w_d;

    // prev word read address: take uses current position, copy/mark sweep idx
    assign w_prev_raddr = i_cmd.take ? r_cur_pos[POS_W-1:0] : r_idx[POS_W-1:0];

    aots_ram #(.WIDTH(LET_W), .DEPTH(MAX_WORD_LEN)) u_prev (
        .i_clk  (i_clk),
        .i_we   (i_cmd.copy_wr),
        .i_waddr(r_idx[POS_W-1:0] - POS_W'(1)),
        .i_wdata(w_cur_rd),
        .i_raddr(w_prev_raddr),
        .o_rdata(w_prev_rd)
    );

    aots_ram #(.WIDTH(LET_W), .DEPTH(MAX_WORD_LEN)) u_cur (
        .i_clk  (i_clk),
        .i_we   (i_cmd.take && r_cur_pos < (POS_W+1)'(MAX_WORD_LEN)),
        .i_waddr(r_cur_pos[POS_W-1:0]),
        .i_wdata(i_item.letter),
        .i_raddr(r_idx[POS_W-1:0]),
        .o_rdata(w_cur_rd)
    );

    assign w_a = w_prev_rd;
    assign w_edge_we = i_cmd.cmp && r_cmp_ok && (w_a != r_letter) &&
                       r_edge_cnt < (EDGE_W+1)'(MAX_EDGES);

    aots_ram #(.WIDTH(2*LET_W), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk  (i_clk),
        .i_we   (w_edge_we),
        .i_waddr(r_edge_cnt[EDGE_W-1:0]),
        .i_wdata({w_a, r_letter}),
        .i_raddr(r_eidx[EDGE_W-1:0]),
        .o_rdata(w_edge_rd)
    );

    assign w_d = w_edge_rd[LET_W-1:0];

    always_comb begin
        n_prev_len = r_prev_len;
        n_cur_pos  = r_cur_pos;
        n_diff     = r_diff;
        n_seen     = r_seen;
        if (i_cmd.take && r_cur_pos < (POS_W+1)'(MAX_WORD_LEN)) begin
            n_cur_pos = r_cur_pos + 1'b1;
        end
        if (i_cmd.cmp && r_cmp_ok) begin
            n_seen[w_a]      = 1'b1;
            n_seen[r_letter] = 1'b1;
            if (w_a != r_letter) begin
                n_diff = 1'b1;
            end
        end
        if (i_cmd.mark_wr) begin
            n_seen[w_prev_rd] = 1'b1;
        end
        if (i_cmd.end_word) begin
            n_prev_len = r_cur_pos;
            n_cur_pos  = '0;
            n_diff     = 1'b0;
        end
        if (i_cmd.clear) begin
            n_prev_len = '0;
            n_cur_pos  = '0;
            n_diff     = 1'b0;
            n_seen     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_len <= '0;
            r_cur_pos  <= '0;
            r_diff     <= 1'b0;
            r_seen     <= '0;
            r_edge_cnt <= '0;
            for (int i = 0; i < LETTERS; i++) begin
                r_indeg[i] <= '0;
            end
        end else begin
            r_prev_len <= n_prev_len;
            r_cur_pos  <= n_cur_pos;
            r_diff     <= n_diff;
            r_seen     <= n_seen;
            if (w_edge_we) begin
                r_edge_cnt        <= r_edge_cnt + 1'b1;
                r_indeg[r_letter] <= r_indeg[r_letter] + 1'b1;
            end
            if (i_cmd.edge_step && r_eidx - 1'b1 < r_edge_cnt &&
                w_edge_rd[2*LET_W-1:LET_W] == r_deq && r_indeg[w_d] != '0) begin
                r_indeg[w_d] <= r_indeg[w_d] - 1'b1;
            end
            if (i_cmd.clear) begin
                r_edge_cnt <= '0;
                for (int i = 0; i < LETTERS; i++) begin
                    r_indeg[i] <= '0;
                end
            end
        end
    end

    // sweep counters, queue and compare staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_letter <= i_item.letter;
            r_cmp_ok <= r_cur_pos < (POS_W+1)'(MAX_WORD_LEN) && r_prev_len != '0 &&
                        !r_diff && r_cur_pos < r_prev_len;
        end
        if (i_cmd.cnt_rst) begin
            r_idx  <= '0;
            r_eidx <= '0;
            r_fill <= '0;
            r_head <= '0;
        end
        if (i_cmd.head_rst) begin
            r_head <= '0;
        end
        if (i_cmd.copy_rd || i_cmd.mark_rd) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan) begin
            if (r_seen[r_idx[4:0]] && r_indeg[r_idx[4:0]] == '0) begin
                r_q[r_fill] <= r_idx[4:0];
                r_fill      <= r_fill + 1'b1;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.deq) begin
            r_deq  <= r_q[r_head];
            r_head <= r_head + 1'b1;
            r_eidx <= '0;
        end
        if (i_cmd.edge_rd) begin
            r_eidx <= r_eidx + 1'b1;
        end
        if (i_cmd.edge_step && r_eidx - 1'b1 < r_edge_cnt &&
            w_edge_rd[2*LET_W-1:LET_W] == r_deq && r_indeg[w_d] == (EDGE_W+1)'(1) &&
            r_fill < 5'(LETTERS)) begin
            r_q[r_fill] <= w_d;
            r_fill      <= r_fill + 1'b1;
        end
        if (i_cmd.emit) begin
            r_head <= r_head + 1'b1;
        end
    end

    assign o_sts.cur_nonzero = r_cur_pos != '0;
    assign o_sts.copy_done   = r_idx >= r_cur_pos;
    assign o_sts.mark_done   = r_idx >= r_prev_len;
    assign o_sts.scan_done   = r_idx[4:0] == 5'(LETTERS - 1);
    assign o_sts.queue_empty = r_head >= r_fill;
    assign o_sts.edge_done   = r_eidx >= r_edge_cnt;
    assign o_sts.emit_last   = r_fill == '0 || r_head + 1'b1 >= r_fill;

    assign o_res.order_letter = (r_fill == '0) ? 5'd0 : r_q[r_head];
    assign o_res.present      = r_fill != '0;
    assign o_res.last         = o_sts.emit_last;
endmodule

/* design/aots_ctrl.sv */
// Controller state machine sequencing word handling and the Kahn sort.
// Depends on aots_pkg.
`timescale 1ns / 1ps
module aots_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  aots_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    input  aots_pkg::t_sts i_sts,
    output aots_pkg::t_cmd o_cmd
);
    import aots_pkg::*;

    t_state r_state, n_state;
    logic   r_endw, n_endw;
    logic   r_edge_live, n_edge_live;
    logic   w_acc, w_ok;

    assign o_stall = r_state != S_IDLE;
    assign w_acc   = i_valid && r_state == S_IDLE;
    assign w_ok    = i_item.letter < 5'(LETTERS) &&
                     (i_item.operation == OP_LETTER || i_item.operation == OP_END);
    assign o_valid = r_state == S_EMIT;

    always_comb begin
        n_state     = r_state;
        n_endw      = r_endw;
        n_edge_live = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_ok) begin
                    o_cmd.take = 1'b1;
                    n_endw     = i_item.operation == OP_END;
                    n_state    = S_CMP;
                end else if (w_acc && i_item.operation == OP_LIST) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state       = i_sts.cur_nonzero ? S_COPYR : S_MARKR;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_endw) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state       = S_COPYR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_COPYR: begin
                // address idx issued; write lands next cycle at idx-1
                o_cmd.copy_rd = 1'b1;
                n_state       = S_COPYW;
            end
            S_COPYW: begin
                o_cmd.copy_wr = 1'b1;
                if (i_sts.copy_done) begin
                    o_cmd.end_word = 1'b1;
                    o_cmd.cnt_rst  = 1'b1;
                    n_state        = r_endw ? S_IDLE : S_MARKR;
                    n_endw         = 1'b0;
                end else begin
                    n_state = S_COPYR;
                end
            end
            S_MARKR: begin
                if (i_sts.mark_done) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state       = S_SCAN;
                end else begin
                    o_cmd.mark_rd = 1'b1;
                    n_state       = S_MARKW;
                end
            end
            S_MARKW: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = S_MARKR;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DEQ;
                end
            end
            S_DEQ: begin
                if (i_sts.queue_empty) begin
                    o_cmd.head_rst = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.deq = 1'b1;
                    n_state   = S_EDGE;
                end
            end
            S_EDGE: begin
                o_cmd.edge_step = r_edge_live;
                if (i_sts.edge_done) begin
                    n_state = S_DEQ;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_edge_live   = 1'b1;
                end
            end
            S_EMIT: begin
                if (!i_stall) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.cnt_rst = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_endw      <= 1'b0;
            r_edge_live <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_endw      <= n_endw;
            r_edge_live <= n_edge_live;
        end
    end
endmodule

/* design/alphabet_order_topological_sort_top.sv */
// Alphabet order topological sort block.
// Input channel: one letter item per transfer (operation, letter); operation
// end of list starts the sort. Output channel: the derived order, one letter
// per transfer, last flagged; an empty order gives one transfer with present 0.
// Each letter is stored and compared with the previous word; a word-ending
// letter also copies the word, letter by letter, into the previous-word store.
// End of list: an unfinished word is copied, the last word's letters marked
// seen, all letters scanned, then for each queued letter the whole edge list is
// walked via the single edge memory read port; then the results are emitted.
// The input is stalled while the block works or results are pending.
// A stalled result holds; the block waits until it is taken.
// Reset (synchronous, active low) clears all control state, indegrees
// and the edge count at once; no clearing pass is needed.
// After the last result all list state is cleared.
// Depends on aots_pkg, aots_ctrl, aots_datapath.
`timescale 1ns / 1ps
module alphabet_order_topological_sort_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  aots_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output aots_pkg::t_out o_data
);
    import aots_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    aots_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    aots_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_data),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_res  (o_data)
    );
endmodule

/* design/aots_checker.sv */
// Port-level checker for the alphabet order topological sort block.
// Depends on aots_pkg; bound to alphabet_order_topological_sort_top.
`timescale 1ns / 1ps
module aots_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input aots_pkg::t_out o_data
);
    import aots_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.order_letter < 5'(LETTERS))
        else $error("letter out of range");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.present |-> o_data.last)
        else $error("empty order not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while results pending");
endmodule

bind alphabet_order_topological_sort_top aots_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);

/* sim/testbench.sv */
// Testbench for alphabet_order_topological_sort_top: drives word lists as letter
// transfers and checks the derived alphabet order against an in-bench Kahn sort model.
// Depends on aots_pkg and the alphabet_order_topological_sort_top RTL.
`timescale 1ns / 1ps
module testbench;
    import aots_pkg::*;

    localparam int LIMIT = 200000;
    localparam logic [1:0] OP_BAD = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    alphabet_order_topological_sort_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // order model state
    logic [4:0]  prev_word [MAX_WORD_LEN];
    int          prev_len;
    logic [4:0]  cur_word [MAX_WORD_LEN];
    int          cur_pos;
    bit          diff_found;
    logic [25:0] seen;
    int          indeg [LETTERS];
    logic [4:0]  edge_src [MAX_EDGES];
    logic [4:0]  edge_dst [MAX_EDGES];
    int          n_edges;

    t_out expected_order [$];
    int   errors = 0;
    bit   quiet = 0;
    longint cycles = 0;

    function automatic void clear_lists();
        prev_len = 0;
        cur_pos = 0;
        diff_found = 0;
        seen = '0;
        n_edges = 0;
        foreach (indeg[k]) indeg[k] = 0;
    endfunction

    function automatic void add_letter(logic [4:0] c);
        int p;
        logic [4:0] a;
        p = cur_pos;
        if (p >= MAX_WORD_LEN) return;
        cur_word[p] = c;
        cur_pos = p + 1;
        if (prev_len > 0 && !diff_found && p < prev_len) begin
            a = prev_word[p];
            seen[a] = 1'b1;
            seen[c] = 1'b1;
            if (a != c) begin
                diff_found = 1;
                if (n_edges < MAX_EDGES) begin
                    edge_src[n_edges] = a;
                    edge_dst[n_edges] = c;
                    n_edges++;
                    indeg[c]++;
                end
            end
        end
    endfunction

    function automatic void close_word();
        if (cur_pos == 0) return;
        for (int k = 0; k < cur_pos; k++) prev_word[k] = cur_word[k];
        prev_len = cur_pos;
        cur_pos = 0;
        diff_found = 0;
    endfunction

    function automatic void sort_alphabet();
        logic [4:0] q [$];
        int head;
        logic [4:0] u;
        logic [4:0] d;
        t_out r;
        close_word();
        for (int k = 0; k < prev_len; k++) seen[prev_word[k]] = 1'b1;
        for (int k = 0; k < LETTERS; k++)
            if (seen[k] && indeg[k] == 0) q.insert(q.size(), 5'(k));
        head = 0;
        while (head < q.size()) begin
            u = q[head];
            head++;
            for (int e = 0; e < n_edges; e++) begin
                d = edge_dst[e];
                if (edge_src[e] != u || indeg[d] == 0) continue;
                indeg[d]--;
                if (indeg[d] == 0 && q.size() < LETTERS) q.insert(q.size(), d);
            end
        end
        if (q.size() == 0) begin
            r = '{order_letter: 5'd0, present: 1'b0, last: 1'b1};
            expected_order.insert(expected_order.size(), r);
        end else begin
            for (int k = 0; k < q.size(); k++) begin
                r = '{order_letter: q[k], present: 1'b1, last: (k == q.size() - 1)};
                expected_order.insert(expected_order.size(), r);
            end
        end
        clear_lists();
    endfunction

    function automatic void predict(t_in t);
        if (t.operation == OP_LIST) begin
            sort_alphabet();
            return;
        end
        if (t.operation == OP_BAD || t.letter >= LETTERS) return;
        add_letter(t.letter);
        if (t.operation == OP_END) close_word();
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("alphabet_order_topological_sort_top test failed");
            $finish;
        end
    end

    // receiver: random stall bursts, compare on transfer
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_order.size() == 0) begin
                $error("unexpected result %p", o_data);
                errors++;
            end else begin
                exp_r = expected_order.pop_front();
                if (o_data.order_letter !== exp_r.order_letter) begin
                    $error("order_letter exp %0d got %0d", exp_r.order_letter,
                           o_data.order_letter);
                    errors++;
                end
                if (o_data.present !== exp_r.present) begin
                    $error("present exp %0d got %0d", exp_r.present, o_data.present);
                    errors++;
                end
                if (o_data.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, o_data.last);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send(logic [1:0] op, logic [4:0] c);
        t_in t;
        int gap;
        t.operation = op;
        t.letter = c;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict(t);
    endtask

    // sender pauses until every expected result has come
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_order.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_word(int len, int span);
        for (int k = 0; k < len; k++)
            send((k == len - 1) ? OP_END : OP_LETTER, 5'($urandom_range(0, span - 1)));
    endtask

    typedef struct {
        logic [1:0] op;
        logic [4:0] c;
        bit         check;
        t_out       fixed;
    } t_row;

    t_row rows [] = '{
        '{OP_LIST,   5'd0,  1, '{5'd0, 1'b0, 1'b1}},   // empty list
        '{OP_END,    5'd25, 0, '0},
        '{OP_LIST,   5'd31, 1, '{5'd25, 1'b1, 1'b1}},  // single letter Z
        '{OP_LETTER, 5'd0,  0, '0},
        '{OP_END,    5'd1,  0, '0},
        '{OP_LETTER, 5'd0,  0, '0},
        '{OP_END,    5'd2,  0, '0},                   // B before C
        '{OP_LETTER, 5'd31, 0, '0},                   // bad letter
        '{OP_BAD,    5'd3,  0, '0},                   // bad operation
        '{OP_END,    5'd25, 0, '0},
        '{OP_LIST,   5'd0,  0, '0},
        '{OP_END,    5'd0,  0, '0},                   // cycle A->B->A
        '{OP_END,    5'd1,  0, '0},
        '{OP_END,    5'd0,  0, '0},
        '{OP_LIST,   5'd0,  1, '{5'd0, 1'b0, 1'b1}},
        '{OP_LETTER, 5'd2,  0, '0},
        '{OP_LETTER, 5'd3,  0, '0},                   // unfinished word
        '{OP_LIST,   5'd0,  0, '0}
    };

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        clear_lists();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            int before_n;
            before_n = expected_order.size();
            send(rows[r].op, rows[r].c);
            if (rows[r].check && expected_order.size() == before_n + 1 &&
                expected_order[before_n] != rows[r].fixed) begin
                $error("table row %0d model mismatch", r);
                errors++;
            end
        end

        // long word past MAX_WORD_LEN, then a second one
        for (int k = 0; k < MAX_WORD_LEN + 2; k++) send(OP_LETTER, 5'(k % LETTERS));
        send(OP_END, 5'd25);
        send_word(3, 26);
        send(OP_LIST, 5'd0);

        drain();

        // random lists
        for (int n = 0; n < 10; n++) begin
            int words;
            int span;
            if (n == 8) quiet = 1;
            span = $urandom_range(2, 26);
            words = $urandom_range(1, 3);
            for (int w = 0; w < words; w++) begin
                if ($urandom_range(0, 9) == 0)
                    send(2'($urandom_range(0, 3)), 5'($urandom));
                else
                    send_word($urandom_range(1, 4), span);
            end
            send(OP_LIST, 5'($urandom));
            if (n == 4) drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("alphabet_order_topological_sort_top test passed");
        end else begin
            $display("alphabet_order_topological_sort_top test failed");
        end
        $finish;
    end
endmodule
